FILE: sv/wpt_pkg.sv
// wpt_pkg: shared types, field widths, codes and the byte classifier
// for the word/punctuation tokenizer. No dependencies.
`timescale 1ns / 1ps

package wpt_pkg;

  localparam int TOKEN_START_W  = 12;
  localparam int TOKEN_LENGTH_W = 13;
  localparam int TOKEN_KIND_W   = 2;
  localparam int TOKEN_TOTAL_W  = 9;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_WORD  = 2'd1;
  localparam logic [1:0] CLS_PUNCT = 2'd2;

  localparam logic [TOKEN_KIND_W-1:0] KIND_WORD     = 2'd0;
  localparam logic [TOKEN_KIND_W-1:0] KIND_PUNCT    = 2'd1;
  localparam logic [TOKEN_KIND_W-1:0] KIND_QUESTION = 2'd2;

  localparam logic [7:0] CH_QUESTION   = 8'h3F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_APOSTROPHE = 8'h27;

  typedef struct packed {
    logic                      is_token;
    logic [TOKEN_START_W-1:0]  token_start;
    logic [TOKEN_LENGTH_W-1:0] token_length;
    logic [TOKEN_KIND_W-1:0]   token_kind;
    logic [TOKEN_TOTAL_W-1:0]  token_total;
    logic                      truncated;
    logic                      last;
  } wpt_result_t;

  typedef struct packed {
    logic        valid;
    logic        two;
    wpt_result_t r0;
    wpt_result_t r1;
  } wpt_push_t;

  function automatic logic [1:0] wpt_classify(input logic [7:0] b);
    logic [1:0] cls;
    cls = CLS_NONE;
    if ((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
        (b >= 8'd97 && b <= 8'd122) || b == CH_APOSTROPHE ||
        b == CH_UNDERSCORE || b == CH_HYPHEN) begin
      cls = CLS_WORD;
    end else if ((b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
                 (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126)) begin
      cls = CLS_PUNCT;
    end
    return cls;
  endfunction

endpackage

FILE: sv/wpt_text_if.sv
// wpt_text_if: input channel of the tokenizer, one text byte or end mark
// per request. Depends on wpt_pkg.
`timescale 1ns / 1ps

interface wpt_text_if import wpt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] text_byte;

  modport source (output valid, output opcode, output text_byte, input ready);
  modport sink (input valid, input opcode, input text_byte, output ready);
endinterface

FILE: sv/wpt_token_if.sv
// wpt_token_if: result channel of the tokenizer, one token or summary per
// request. Depends on wpt_pkg.
`timescale 1ns / 1ps

interface wpt_token_if import wpt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      is_token;
  logic [TOKEN_START_W-1:0]  token_start;
  logic [TOKEN_LENGTH_W-1:0] token_length;
  logic [TOKEN_KIND_W-1:0]   token_kind;
  logic [TOKEN_TOTAL_W-1:0]  token_total;
  logic                      truncated;
  logic                      last;

  modport source (output valid, output is_token, output token_start, output token_length,
                  output token_kind, output token_total, output truncated, output last,
                  input ready);
  modport sink (input valid, input is_token, input token_start, input token_length,
                input token_kind, input token_total, input truncated, input last,
                output ready);
endinterface

FILE: sv/wpt_result_fifo.sv
// wpt_result_fifo: two-entry result queue, each entry one or two results,
// drained one result per request. Depends on wpt_pkg and wpt_token_if.
`timescale 1ns / 1ps

module wpt_result_fifo import wpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  wpt_push_t          push,
  output logic               full,
  wpt_token_if.source        tokens
);

  wpt_push_t   ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        sub;
  wpt_push_t   head;
  wpt_result_t res;
  logic        pop_res;
  logic        pop_ent;

  assign head    = ent[rptr];
  assign res     = sub ? head.r1 : head.r0;
  assign full    = (count == 2'd2);
  assign pop_res = tokens.valid && tokens.ready;
  assign pop_ent = pop_res && (sub || !head.two);

  assign tokens.valid        = (count != 2'd0);
  assign tokens.is_token     = res.is_token;
  assign tokens.token_start  = res.token_start;
  assign tokens.token_length = res.token_length;
  assign tokens.token_kind   = res.token_kind;
  assign tokens.token_total  = res.token_total;
  assign tokens.truncated    = res.truncated;
  assign tokens.last         = res.last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent[wptr] <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
      sub   <= 1'b0;
    end else begin
      if (push.valid) begin
        wptr <= ~wptr;
      end
      if (pop_ent) begin
        rptr <= ~rptr;
      end
      if (pop_res) begin
        sub <= !pop_ent;
      end
      count <= count + {1'b0, push.valid} - {1'b0, pop_ent};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push.valid)
    else $error("push into full result queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  a_sub_two: assert property (@(posedge clk) disable iff (rst) sub |-> (head.two && count != 2'd0))
    else $error("second slot read from single-result entry");
  a_sub_last: assert property (@(posedge clk) disable iff (rst)
      (tokens.valid && sub) |-> tokens.last)
    else $error("second result of an entry not marked last");
`endif

endmodule

FILE: sv/word_punct_tokenizer.sv
// word_punct_tokenizer: splits a byte stream into word and punctuation
// tokens. Depends on wpt_pkg, wpt_text_if, wpt_token_if, wpt_result_fifo.
`timescale 1ns / 1ps
//
// channel  | dir | payload
// ---------+-----+-------------------------------------------------------
// text     | in  | opcode, text_byte
// tokens   | out | is_token, token_start, token_length, token_kind,
//          |     | token_total, truncated, last
//
// one request per ready cycle; a byte's token is queued the same edge
// an end mark queues up to two results, drained one per ready cycle
// results are registered in the result queue, which holds two entries
// text.ready drops only while the result queue is full
// rst clears the run state, counters and queue; no clearing pass

module word_punct_tokenizer import wpt_pkg::*; #(
  parameter int MAX_TOKENS = 256,
  parameter int MAX_TEXT   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  wpt_text_if.sink    text,
  wpt_token_if.source tokens
);

  localparam int POS_W   = $clog2(MAX_TEXT + 1);
  localparam int START_W = $clog2(MAX_TEXT);
  localparam int CNT_W   = $clog2(MAX_TOKENS + 1);

  logic [1:0]         run_mode;
  logic [START_W-1:0] run_start;
  logic [POS_W-1:0]   run_length;
  logic               run_is_question;
  logic [POS_W-1:0]   byte_position;
  logic [CNT_W-1:0]   token_counter;
  logic               dropped_flag;

  logic [1:0]         run_mode_next;
  logic [START_W-1:0] run_start_next;
  logic [POS_W-1:0]   run_length_next;
  logic               run_is_question_next;
  logic [POS_W-1:0]   byte_position_next;
  logic [CNT_W-1:0]   token_counter_next;
  logic               dropped_flag_next;

  logic               accept;
  logic               full;
  logic               eot;
  logic               pos_ok;
  logic [1:0]         cls;
  logic               do_close;
  logic               emit;
  logic               close_drop;
  logic [CNT_W-1:0]   cnt_after;
  logic [TOKEN_KIND_W-1:0] kind;
  wpt_result_t        tok_res;
  wpt_result_t        sum_res;
  wpt_push_t          push;

  assign text.ready = !full;
  assign accept     = text.valid && text.ready;
  assign eot        = (text.opcode == OP_END);
  assign pos_ok     = (byte_position < POS_W'(MAX_TEXT));
  assign cls        = wpt_classify(text.text_byte);
  assign do_close   = (run_mode != CLS_NONE) && (eot || (pos_ok && cls != run_mode));
  assign emit       = do_close && (token_counter < CNT_W'(MAX_TOKENS));
  assign close_drop = do_close && !emit;
  assign cnt_after  = token_counter + CNT_W'(emit);

  always_comb begin
    kind = KIND_WORD;
    if (run_mode == CLS_PUNCT) begin
      kind = (run_length == POS_W'(1) && run_is_question) ? KIND_QUESTION : KIND_PUNCT;
    end
  end

  always_comb begin
    tok_res.is_token     = 1'b1;
    tok_res.token_start  = TOKEN_START_W'(run_start);
    tok_res.token_length = TOKEN_LENGTH_W'(run_length);
    tok_res.token_kind   = kind;
    tok_res.token_total  = TOKEN_TOTAL_W'(cnt_after);
    tok_res.truncated    = dropped_flag;
    tok_res.last         = !eot;

    sum_res.is_token     = 1'b0;
    sum_res.token_start  = '0;
    sum_res.token_length = '0;
    sum_res.token_kind   = KIND_WORD;
    sum_res.token_total  = TOKEN_TOTAL_W'(cnt_after);
    sum_res.truncated    = dropped_flag || close_drop;
    sum_res.last         = 1'b1;

    push.valid = accept && (eot || emit);
    push.two   = eot && emit;
    push.r0    = (eot && !emit) ? sum_res : tok_res;
    push.r1    = sum_res;
  end

  always_comb begin
    run_mode_next        = run_mode;
    run_start_next       = run_start;
    run_length_next      = run_length;
    run_is_question_next = run_is_question;
    byte_position_next   = byte_position;
    token_counter_next   = token_counter;
    dropped_flag_next    = dropped_flag;
    if (eot) begin
      run_mode_next        = CLS_NONE;
      run_start_next       = '0;
      run_length_next      = '0;
      run_is_question_next = 1'b0;
      byte_position_next   = '0;
      token_counter_next   = '0;
      dropped_flag_next    = 1'b0;
    end else if (!pos_ok) begin
      dropped_flag_next = 1'b1;
    end else begin
      token_counter_next = cnt_after;
      dropped_flag_next  = dropped_flag || close_drop;
      byte_position_next = byte_position + POS_W'(1);
      if (do_close) begin
        run_mode_next        = CLS_NONE;
        run_start_next       = '0;
        run_length_next      = '0;
        run_is_question_next = 1'b0;
      end
      if (cls != CLS_NONE) begin
        if (run_mode == cls) begin
          run_length_next = run_length + POS_W'(1);
        end else begin
          run_mode_next        = cls;
          run_start_next       = START_W'(byte_position);
          run_length_next      = POS_W'(1);
          run_is_question_next = (text.text_byte == CH_QUESTION);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode        <= CLS_NONE;
      run_start       <= '0;
      run_length      <= '0;
      run_is_question <= 1'b0;
      byte_position   <= '0;
      token_counter   <= '0;
      dropped_flag    <= 1'b0;
    end else if (accept) begin
      run_mode        <= run_mode_next;
      run_start       <= run_start_next;
      run_length      <= run_length_next;
      run_is_question <= run_is_question_next;
      byte_position   <= byte_position_next;
      token_counter   <= token_counter_next;
      dropped_flag    <= dropped_flag_next;
    end
  end

  wpt_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .tokens (tokens)
  );

`ifndef NO_ASSERTIONS
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
      byte_position <= POS_W'(MAX_TEXT))
    else $error("byte position past text limit");
  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
      token_counter <= CNT_W'(MAX_TOKENS))
    else $error("token counter past token limit");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
      (run_mode != CLS_NONE) == (run_length != '0))
    else $error("open run and run length disagree");
  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
      (accept && eot) |=> (byte_position == '0 && token_counter == '0 && !dropped_flag))
    else $error("state not cleared after end of text");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for word_punct_tokenizer; streams text bytes and end marks,
// predicts every token and summary, and checks the results in order.
// Depends on wpt_pkg, wpt_text_if, wpt_token_if and the tokenizer RTL.

module tb;
  import wpt_pkg::*;

  localparam int MAX_TOKENS   = 256;
  localparam int MAX_TEXT     = 4096;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 128;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic       opcode;
    logic [7:0] text_byte;
  } text_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wpt_text_if  text ();
  wpt_token_if tokens ();

  word_punct_tokenizer #(
    .MAX_TOKENS(MAX_TOKENS),
    .MAX_TEXT  (MAX_TEXT)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .tokens(tokens)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_req_t   text_queue[$];
  wpt_result_t expected_tokens[$];
  wpt_result_t step_results[$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic text_taken = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   queued_count = 0;
  int   accepted_count = 0;
  int   results_checked = 0;
  int   tokens_seen = 0;
  int   summaries_seen = 0;
  int   truncated_texts = 0;

  // predicted tokenizer state
  logic [1:0] open_cls;
  int         open_start;
  int         open_len;
  logic       open_question;
  int         next_pos;
  int         emitted;
  logic       dropped;

  task automatic report(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  function automatic logic [1:0] byte_class(input logic [7:0] b);
    if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                  CH_APOSTROPHE, CH_UNDERSCORE, CH_HYPHEN}) begin
      return CLS_WORD;
    end
    if (b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]}) begin
      return CLS_PUNCT;
    end
    return CLS_NONE;
  endfunction

  task automatic reset_text_state();
    open_cls = CLS_NONE;
    open_start = 0;
    open_len = 0;
    open_question = 1'b0;
    next_pos = 0;
    emitted = 0;
    dropped = 1'b0;
  endtask

  function automatic wpt_result_t make_result(input logic is_tok, input int start,
                                              input int len, input logic [1:0] kind);
    wpt_result_t r;
    r.is_token     = is_tok;
    r.token_start  = TOKEN_START_W'(start);
    r.token_length = TOKEN_LENGTH_W'(len);
    r.token_kind   = kind;
    r.token_total  = TOKEN_TOTAL_W'(emitted);
    r.truncated    = dropped;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic close_run();
    logic [1:0] kind;
    if (open_cls != CLS_NONE) begin
      if (emitted >= MAX_TOKENS) begin
        dropped = 1'b1;
      end else begin
        kind = KIND_WORD;
        if (open_cls == CLS_PUNCT) begin
          kind = (open_len == 1 && open_question) ? KIND_QUESTION : KIND_PUNCT;
        end
        emitted++;
        step_results.push_back(make_result(1'b1, open_start, open_len, kind));
      end
    end
    open_cls = CLS_NONE;
    open_start = 0;
    open_len = 0;
    open_question = 1'b0;
  endtask

  task automatic tokenize_step(input text_req_t req);
    logic [1:0]  cls;
    wpt_result_t r;
    step_results = {};
    if (req.opcode == OP_END) begin
      close_run();
      step_results.push_back(make_result(1'b0, 0, 0, KIND_WORD));
      reset_text_state();
    end else if (next_pos >= MAX_TEXT) begin
      dropped = 1'b1;
    end else begin
      cls = byte_class(req.text_byte);
      if (open_cls != CLS_NONE && cls != open_cls) begin
        close_run();
      end
      if (cls != CLS_NONE) begin
        if (open_cls == cls) begin
          open_len++;
        end else begin
          open_cls = cls;
          open_start = next_pos;
          open_len = 1;
          open_question = (req.text_byte == CH_QUESTION);
        end
      end
      next_pos++;
    end
    foreach (step_results[i]) begin
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_tokens.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("result %0d: %s is %0d, expected %0d", results_checked, name,
                       got, want));
    end
  endtask

  // request acceptance and result checking, both on the rising edge
  always @(posedge clk) begin : monitor
    wpt_result_t got;
    wpt_result_t want;
    cycle_count++;
    if (rst) begin
      text_taken <= 1'b0;
    end else begin
      text_taken <= text.valid && text.ready;
      if (text.valid && text.ready) begin
        tokenize_step('{text.opcode, text.text_byte});
        accepted_count++;
      end
      if (tokens.valid && tokens.ready) begin
        got.is_token     = tokens.is_token;
        got.token_start  = tokens.token_start;
        got.token_length = tokens.token_length;
        got.token_kind   = tokens.token_kind;
        got.token_total  = tokens.token_total;
        got.truncated    = tokens.truncated;
        got.last         = tokens.last;
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected result, is_token %0b start %0d length %0d",
                           got.is_token, got.token_start, got.token_length));
        end else begin
          want = expected_tokens.pop_front();
          check_field("is_token", got.is_token, want.is_token);
          check_field("token_start", got.token_start, want.token_start);
          check_field("token_length", got.token_length, want.token_length);
          check_field("token_kind", got.token_kind, want.token_kind);
          check_field("token_total", got.token_total, want.token_total);
          check_field("truncated", got.truncated, want.truncated);
          check_field("last", got.last, want.last);
          if (want.is_token) begin
            tokens_seen++;
          end else begin
            summaries_seen++;
            if (want.truncated) begin
              truncated_texts++;
            end
          end
        end
        results_checked++;
      end
    end
  end

  // inputs change on the falling edge
  always @(negedge clk) begin : driver
    text_req_t req;
    if (rst) begin
      text.valid <= 1'b0;
      tokens.ready <= 1'b0;
    end else begin
      if (!text.valid || text_taken) begin
        if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = text_queue.pop_front();
          text.valid <= 1'b1;
          text.opcode <= req.opcode;
          text.text_byte <= req.text_byte;
        end else begin
          text.valid <= 1'b0;
        end
      end
      tokens.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    text_queue.push_back('{OP_BYTE, b});
    queued_count++;
  endtask

  task automatic push_end();
    text_queue.push_back('{OP_END, 8'($urandom_range(0, 255))});
    queued_count++;
  endtask

  task automatic push_string(input string s);
    foreach (s[i]) begin
      push_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      2: return 8'($urandom_range(8'h30, 8'h39));
      3: return 8'($urandom_range(8'h61, 8'h7A));
      default: begin
        case ($urandom_range(0, 2))
          0: return CH_APOSTROPHE;
          1: return CH_UNDERSCORE;
          default: return CH_HYPHEN;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] punct_char();
    if ($urandom_range(0, 3) == 0) begin
      return CH_QUESTION;
    end
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h21, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'h20;
      2: return 8'h09;
      3: return 8'h0A;
      4: return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(8'h00, 8'h20));
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return word_char();
    if (pick < 70) return punct_char();
    if (pick < 85) return blank_char();
    if (pick < 92) return 8'($urandom_range(8'h7F, 8'hFF));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_short_text();
    int len;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    repeat (len) push_byte(text_char());
    push_end();
  endtask

  // alternating word and punctuation bytes, enough tokens to pass the count limit
  task automatic add_long_text();
    repeat ($urandom_range(170, 190)) begin
      push_byte(word_char());
      push_byte(punct_char());
    end
    push_end();
  endtask

  task automatic wait_idle();
    while (accepted_count < queued_count || expected_tokens.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int phase_start;
    text.valid = 1'b0;
    text.opcode = OP_BYTE;
    text.text_byte = 8'h00;
    tokens.ready = 1'b0;
    reset_text_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // class changes, extremes of each class, high and control bytes
    push_string("Az09'_-x? ?!");
    push_byte(8'h80);
    push_string("{~/:@[");
    push_byte(8'h60);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_string("q");
    push_end();
    push_end();
    push_string("?");
    push_end();
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (p == 0) begin
        add_long_text();
      end
      phase_start = queued_count;
      while (queued_count - phase_start < PHASE_ITEMS) begin
        add_short_text();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_tokens.size() > 0) begin
      report($sformatf("%0d expected results never arrived", expected_tokens.size()));
    end
    $display("covered %0d text requests giving %0d tokens and %0d end-of-text summaries",
             accepted_count, tokens_seen, summaries_seen);
    $display("%0d texts hit a limit; %0d mismatches", truncated_texts, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

endmodule
